@@ design/lrsp_pkg.sv @@
// Package for the LED row-scan PWM block: sizes, word types, state and kind codes,
// and the command/status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package lrsp_pkg;

  localparam int ROWS       = 16;
  localparam int WORD_BITS  = 32;
  localparam int ROW_W      = $clog2(ROWS);
  localparam int TICK_W     = 16;
  localparam int PROD_W     = 2 * TICK_W;
  localparam int DIV_CNT_W  = $clog2(TICK_W);

  localparam logic [TICK_W-1:0] ROW_PERIOD_RST = TICK_W'(520);

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [ROW_W-1:0]     row_t;
  typedef logic [TICK_W-1:0]    tick_t;

  typedef enum logic [1:0] {
    KIND_WORD   = 2'd0,
    KIND_BRIGHT = 2'd1,
    KIND_TICK   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV_INIT,
    ST_DIV_RUN,
    ST_TICK
  } state_e;

  typedef struct packed {
    logic wr_word;
    logic wr_bright;
    logic latch;
    logic div_init;
    logic div_step;
    logic tick;
  } dp_cmd_t;

  typedef struct packed {
    logic frame_start;
    logic slow_path;
    logic div_last;
    logic has_result;
  } dp_status_t;

endpackage

@@ design/lrsp_in_if.sv @@
// Input channel of the LED row-scan PWM block: valid/ready plus the item fields.
// Depends on lrsp_pkg for the row and word types.
`timescale 1ns / 1ps

interface lrsp_in_if;
  logic                 valid;
  logic                 ready;
  logic [1:0]           kind;
  lrsp_pkg::row_t       row_select;
  lrsp_pkg::word_t      row_word;
  lrsp_pkg::tick_t      duty;
  lrsp_pkg::tick_t      scale;

  modport source (output valid, kind, row_select, row_word, duty, scale, input ready);
  modport sink   (input valid, kind, row_select, row_word, duty, scale, output ready);
endinterface

@@ design/lrsp_out_if.sv @@
// Result channel of the LED row-scan PWM block: valid/ready plus the result fields.
// Depends on lrsp_pkg for the row and word types.
`timescale 1ns / 1ps

interface lrsp_out_if;
  logic                 valid;
  logic                 ready;
  lrsp_pkg::word_t      shift_word;
  lrsp_pkg::row_t       shown_row;
  logic                 blanking;

  modport source (output valid, shift_word, shown_row, blanking, input ready);
  modport sink   (input valid, shift_word, shown_row, blanking, output ready);
endinterface

@@ design/lrsp_ctrl.sv @@
// Controller of the LED row-scan PWM block: handshake, sequencing of the frame latch
// and the on-time divider, and the result valid flag. Depends on lrsp_pkg.
`timescale 1ns / 1ps

module lrsp_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic [1:0]            in_kind_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output lrsp_pkg::dp_cmd_t     cmd_o,
  input  lrsp_pkg::dp_status_t  status_i
);
  import lrsp_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  assign in_ready_o  = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && in_kind_i == KIND_TICK && status_i.frame_start) begin
          state_d = status_i.slow_path ? ST_DIV_INIT : ST_TICK;
        end
      end
      ST_DIV_INIT: state_d = ST_DIV_RUN;
      ST_DIV_RUN: begin
        if (status_i.div_last) begin
          state_d = ST_TICK;
        end
      end
      ST_TICK: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_kind_i)
            KIND_WORD:   cmd_o.wr_word   = 1'b1;
            KIND_BRIGHT: cmd_o.wr_bright = 1'b1;
            KIND_TICK: begin
              if (status_i.frame_start) begin
                cmd_o.latch = 1'b1;
              end else begin
                cmd_o.tick = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_DIV_INIT: cmd_o.div_init = 1'b1;
      ST_DIV_RUN:  cmd_o.div_step = 1'b1;
      ST_TICK:     cmd_o.tick     = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.tick && status_i.has_result) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_frame_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_kind_i == KIND_TICK && status_i.frame_start)
      |=> (state_q == ST_DIV_INIT || state_q == ST_TICK))
    else $error("frame-start tick did not enter the latch sequence");

  a_div_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV_RUN && status_i.div_last) |=> state_q == ST_TICK)
    else $error("divider finished without showing the row");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.tick && status_i.has_result) |-> (!out_valid_q || out_ready_i))
    else $error("result register loaded while a result was still pending");

endmodule

@@ design/lrsp_dp.sv @@
// Datapath of the LED row-scan PWM block: row buffers, brightness, scan counters,
// on-time multiplier and shift-subtract divider, result register. Depends on lrsp_pkg.
`timescale 1ns / 1ps

module lrsp_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  lrsp_pkg::tick_t       cfg_wdata_i,
  input  lrsp_pkg::row_t        row_select_i,
  input  lrsp_pkg::word_t       row_word_i,
  input  lrsp_pkg::tick_t       duty_i,
  input  lrsp_pkg::tick_t       scale_i,
  input  lrsp_pkg::dp_cmd_t     cmd_i,
  output lrsp_pkg::dp_status_t  status_o,
  output lrsp_pkg::word_t       shift_word_o,
  output lrsp_pkg::row_t        shown_row_o,
  output logic                  blanking_o
);
  import lrsp_pkg::*;

  word_t               back_q  [ROWS];
  word_t               front_q [ROWS];
  tick_t               duty_q, scale_q;
  tick_t               period_cfg_q;
  tick_t               on_ticks_q;
  row_t                row_q;
  tick_t               tick_q;
  logic [PROD_W-1:0]   prod_q;
  tick_t               rem_q, quo_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  word_t               word_q;
  row_t                shown_q;
  logic                blank_q;

  tick_t               period;
  logic                has_result;
  logic                res_blank;
  word_t               res_word;
  logic [TICK_W:0]     tick_inc;
  logic [TICK_W:0]     rem_shift;
  logic                q_bit;
  tick_t               rem_d, quo_d;
  tick_t               fast_on;

  // A zero period behaves as one tick.
  assign period = (period_cfg_q == '0) ? tick_t'(1) : period_cfg_q;

  assign status_o.frame_start = (tick_q == '0) && (row_q == '0);
  assign status_o.slow_path   = (duty_q != '0) && (scale_q != '0) && (duty_q < scale_q);
  assign status_o.div_last    = (cnt_q == '1);
  assign status_o.has_result  = has_result;

  assign fast_on = (duty_q == '0 || scale_q == '0) ? '0 : period;

  always_comb begin
    has_result = 1'b0;
    res_blank  = 1'b1;
    res_word   = '1;
    if (tick_q == '0) begin
      has_result = 1'b1;
      if (on_ticks_q != '0) begin
        res_blank = 1'b0;
        res_word  = front_q[row_q];
      end
    end else if (tick_q == on_ticks_q && on_ticks_q < period) begin
      has_result = 1'b1;
    end
  end

  assign tick_inc = {1'b0, tick_q} + (TICK_W+1)'(1);

  // One restoring step: the remainder stays below the divisor.
  assign rem_shift = {rem_q, quo_q[TICK_W-1]};
  assign q_bit     = (rem_shift >= {1'b0, scale_q});
  assign rem_d     = q_bit ? TICK_W'(rem_shift - {1'b0, scale_q}) : rem_shift[TICK_W-1:0];
  assign quo_d     = {quo_q[TICK_W-2:0], q_bit};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ROWS; i++) begin
        back_q[i]  <= '0;
        front_q[i] <= '0;
      end
      duty_q       <= '0;
      scale_q      <= '0;
      period_cfg_q <= ROW_PERIOD_RST;
      on_ticks_q   <= '0;
      row_q        <= '0;
      tick_q       <= '0;
      cnt_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        period_cfg_q <= cfg_wdata_i;
      end
      if (cmd_i.wr_word) begin
        back_q[row_select_i] <= row_word_i;
      end
      if (cmd_i.wr_bright) begin
        duty_q  <= duty_i;
        scale_q <= scale_i;
      end
      if (cmd_i.latch) begin
        for (int i = 0; i < ROWS; i++) begin
          front_q[i] <= back_q[i];
        end
        on_ticks_q <= fast_on;
      end
      if (cmd_i.div_init) begin
        cnt_q <= '0;
      end
      if (cmd_i.div_step) begin
        cnt_q <= cnt_q + DIV_CNT_W'(1);
        if (status_o.div_last) begin
          on_ticks_q <= quo_d;
        end
      end
      if (cmd_i.tick) begin
        if (tick_inc >= {1'b0, period}) begin
          tick_q <= '0;
          row_q  <= (row_q == row_t'(ROWS - 1)) ? '0 : row_q + row_t'(1);
        end else begin
          tick_q <= tick_inc[TICK_W-1:0];
        end
      end
    end
  end

  // Payload registers: multiplier, divider and result.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      prod_q <= PROD_W'(period) * PROD_W'(duty_q);
    end
    if (cmd_i.div_init) begin
      rem_q <= prod_q[PROD_W-1:TICK_W];
      quo_q <= prod_q[TICK_W-1:0];
    end
    if (cmd_i.div_step) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
    if (cmd_i.tick && has_result) begin
      word_q  <= res_word;
      shown_q <= row_q;
      blank_q <= res_blank;
    end
  end

  assign shift_word_o = word_q;
  assign shown_row_o  = shown_q;
  assign blanking_o   = blank_q;

endmodule

@@ design/led_row_scan_pwm.sv @@
// Top level of the LED row-scan PWM block: joins controller and datapath to the
// channel interfaces. Depends on lrsp_pkg, lrsp_in_if, lrsp_out_if, lrsp_ctrl, lrsp_dp.
`timescale 1ns / 1ps

// Usage:
//   item_i carries one item per transfer: kind 0 writes a row word into the back
//   buffer, kind 1 sets the pending duty and scale, kind 2 advances one tick, kind 3
//   is dropped. result_o carries a shift word, the shown row and the blanking flag;
//   only ticks that load the shift chain produce a transfer.
//   cfg_we_i/cfg_wdata_i write the row period (ticks per row, zero acts as one).
// Sequencing:
//   Word, brightness and ordinary tick items complete in their transfer; an ordinary
//   tick's result sits in the output register in the cycle after its transfer.
//   The tick at the start of row 0 latches the frame and recomputes the on-time.
//   With duty zero, scale zero or duty at least scale it goes straight to the tick;
//   otherwise a 16x16 multiply and a 16-step shift-subtract divider run first.
//   item_i holds ready low until that sequence ends.
// Reset:
//   rst_ni clears both row buffers, brightness, counters and the result valid;
//   the row period returns to 520.
// Stall:
//   While a result waits and the receiver holds ready low, item_i holds ready low.

module led_row_scan_pwm (
  input  logic            clk_i,
  input  logic            rst_ni,
  lrsp_in_if.sink         item_i,
  lrsp_out_if.source      result_o,
  input  logic            cfg_we_i,
  input  lrsp_pkg::tick_t cfg_wdata_i
);
  import lrsp_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequence the item handshake and the frame latch.
  lrsp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_i.valid),
    .in_kind_i   (item_i.kind),
    .in_ready_o  (item_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  // Hold buffers, counters and the result payload.
  lrsp_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .row_select_i (item_i.row_select),
    .row_word_i   (item_i.row_word),
    .duty_i       (item_i.duty),
    .scale_i      (item_i.scale),
    .cmd_i        (cmd),
    .status_o     (status),
    .shift_word_o (result_o.shift_word),
    .shown_row_o  (result_o.shown_row),
    .blanking_o   (result_o.blanking)
  );

endmodule
